// ===== hdl/drd_pkg.sv =====
package drd_pkg;

   localparam int unsigned RunByteWidth = 8;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned ClusterWidth = 64;
   localparam logic [2:0] MaxField = 3'd4;
   localparam logic [3:0] NibbleMax = 4'd4;

   typedef enum logic [1:0] {
      ST_RUN       = 2'd0,
      ST_END       = 2'd1,
      ST_BAD_HDR   = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_OFFSET = 2'd2,
      PH_IGNORE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [RunByteWidth-1:0] run_byte;
      logic                    final_byte;
   } req_type;

   typedef struct packed {
      status_type                     status;
      logic signed [ClusterWidth-1:0] start_cluster;
      logic [CountWidth-1:0]          cluster_count;
   } rsp_type;

   // Result of one decode step, handed from the core to the output register.
   typedef struct packed {
      logic    emit;
      rsp_type payload;
   } step_res_type;

endpackage

// ===== hdl/data_run_decoder.sv =====
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   drd_pkg::req_type (run_byte, final_byte)
// rsp_      out        rsp_valid / rsp_stall   drd_pkg::rsp_type (status, start_cluster,
//                                                                  cluster_count)
//
// One run-list byte is decoded per clock cycle unless a held rsp_stall blocks the
// result register; a new request transaction can be accepted in every cycle in which
// req_stall is low. A byte that produces a result waits in the input register, is
// decoded once the result register is free, and its result is then registered there.
// The rate is set by the single decode pass: one accumulate and one 64-bit add.
// Reset is synchronous and active high; it empties both registers and clears the
// decoder state, the previous start cluster included.
// A held rsp_stall keeps the result register full and stops decoding; the input
// register can still take one transaction, after which req_stall rises until the
// waiting result is taken.
module data_run_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  drd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output drd_pkg::rsp_type rsp_payload
);
   import drd_pkg::*;

   // Decoupling between the input register and the result register: a byte moves
   // through the decoder only when the result register can take what it produces.
   logic         item_valid;
   req_type      item;
   logic         out_free;
   logic         step;
   step_res_type res;

   assign step = item_valid && out_free;

   drd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .step        (step),
      .item_valid  (item_valid),
      .item        (item)
   );

   // The decoder holds the run-list state: phase, field byte counts, the two
   // accumulators and the start cluster of the last run with an offset.
   drd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item),
      .res   (res)
   );

   drd_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .res         (res),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A decoded byte that emits a result must show it in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      step && res.emit |=> rsp_valid)
   else $error("emitted result did not reach the result register");

   // No byte may be decoded while a waiting result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !step)
   else $error("decode step while the result register was blocked");

   // Only a decoded run carries a start cluster or a cluster count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_RUN |->
         rsp_payload.start_cluster == '0 && rsp_payload.cluster_count == '0)
   else $error("non-run result carries run fields");

   // A stalled request side always means a byte is waiting in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid && !out_free)
   else $error("request stalled without a held byte");

endmodule

// ===== hdl/drd_in_stage.sv =====
module drd_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  drd_pkg::req_type req_payload,
   input  logic             step,
   output logic             item_valid,
   output drd_pkg::req_type item
);
   import drd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    accept;

   // The stage frees up whenever its held byte is consumed in this cycle.
   assign req_stall = valid_ff && !step;
   assign accept = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// ===== hdl/drd_core.sv =====
module drd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  drd_pkg::req_type      item,
   output drd_pkg::step_res_type res
);
   import drd_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [2:0]              bytes_left_ff, bytes_left_in;
   logic [2:0]              length_size_ff, length_size_in;
   logic [2:0]              offset_size_ff, offset_size_in;
   logic [CountWidth-1:0]   length_accum_ff, length_accum_in;
   logic [CountWidth-1:0]   offset_accum_ff, offset_accum_in;
   logic [ClusterWidth-1:0] prev_cluster_ff, prev_cluster_in;

   logic [3:0]              hdr_len;
   logic [3:0]              hdr_off;
   logic [2:0]              left_dec;
   logic [2:0]              len_pos_full;
   logic [2:0]              off_pos_full;
   logic [CountWidth-1:0]   length_new;
   logic [CountWidth-1:0]   offset_new;
   logic [ClusterWidth-1:0] offset_sext;
   logic [ClusterWidth-1:0] start_sum;
   logic                    field_done;
   logic                    sparse_done;

   // Place a byte into a little-endian accumulator at a byte position.
   function automatic logic [CountWidth-1:0] place_byte(
      input logic [CountWidth-1:0]   acc,
      input logic [RunByteWidth-1:0] b,
      input logic [1:0]              pos
   );
      logic [CountWidth-1:0] r;
      r = acc;
      case (pos)
         2'd0:    r[7:0]   = r[7:0]   | b;
         2'd1:    r[15:8]  = r[15:8]  | b;
         2'd2:    r[23:16] = r[23:16] | b;
         2'd3:    r[31:24] = r[31:24] | b;
         default: r = acc;
      endcase
      return r;
   endfunction

   assign hdr_len = item.run_byte[3:0];
   assign hdr_off = item.run_byte[7:4];
   assign left_dec = bytes_left_ff - 3'd1;
   assign len_pos_full = length_size_ff - bytes_left_ff;
   assign off_pos_full = offset_size_ff - bytes_left_ff;
   assign length_new = place_byte(length_accum_ff, item.run_byte, len_pos_full[1:0]);
   assign offset_new = place_byte(offset_accum_ff, item.run_byte, off_pos_full[1:0]);
   assign field_done = (left_dec == 3'd0) || (left_dec > MaxField);

   // Sign extension of the offset field from its own size.
   always_comb begin
      case (offset_size_ff)
         3'd1:    offset_sext = {{56{offset_new[7]}}, offset_new[7:0]};
         3'd2:    offset_sext = {{48{offset_new[15]}}, offset_new[15:0]};
         3'd3:    offset_sext = {{40{offset_new[23]}}, offset_new[23:0]};
         3'd4:    offset_sext = {{32{offset_new[31]}}, offset_new[31:0]};
         default: offset_sext = '0;
      endcase
   end

   assign start_sum = prev_cluster_ff + offset_sext;

   always_comb begin
      phase_in        = phase_ff;
      bytes_left_in   = bytes_left_ff;
      length_size_in  = length_size_ff;
      offset_size_in  = offset_size_ff;
      length_accum_in = length_accum_ff;
      offset_accum_in = offset_accum_ff;
      prev_cluster_in = prev_cluster_ff;
      sparse_done     = 1'b0;
      res.emit                  = 1'b0;
      res.payload.status        = ST_RUN;
      res.payload.start_cluster = '0;
      res.payload.cluster_count = '0;

      if (step) begin
         case (phase_ff)
            PH_HEADER: begin
               if (item.run_byte == '0) begin
                  res.emit = 1'b1;
                  res.payload.status = ST_END;
                  phase_in = PH_IGNORE;
               end else if (hdr_len > NibbleMax || hdr_off > NibbleMax) begin
                  res.emit = 1'b1;
                  res.payload.status = ST_BAD_HDR;
                  phase_in = PH_IGNORE;
               end else begin
                  length_size_in  = hdr_len[2:0];
                  offset_size_in  = hdr_off[2:0];
                  length_accum_in = '0;
                  offset_accum_in = '0;
                  if (hdr_len != 4'd0) begin
                     phase_in = PH_LENGTH;
                     bytes_left_in = hdr_len[2:0];
                  end else begin
                     phase_in = PH_OFFSET;
                     bytes_left_in = hdr_off[2:0];
                  end
                  if (item.final_byte) begin
                     res.emit = 1'b1;
                     res.payload.status = ST_TRUNCATED;
                  end
               end
            end
            PH_LENGTH: begin
               length_accum_in = length_new;
               bytes_left_in = left_dec;
               if (field_done) begin
                  if (offset_size_ff == 3'd0) begin
                     // Sparse run: it gives nothing and keeps the previous start.
                     phase_in = PH_HEADER;
                     sparse_done = 1'b1;
                  end else begin
                     phase_in = PH_OFFSET;
                     bytes_left_in = offset_size_ff;
                  end
               end
               if (item.final_byte && !sparse_done) begin
                  res.emit = 1'b1;
                  res.payload.status = ST_TRUNCATED;
               end
            end
            PH_OFFSET: begin
               offset_accum_in = offset_new;
               bytes_left_in = left_dec;
               if (field_done) begin
                  prev_cluster_in = start_sum;
                  res.emit = 1'b1;
                  res.payload.status = ST_RUN;
                  res.payload.start_cluster = start_sum;
                  res.payload.cluster_count = length_accum_ff;
                  phase_in = PH_HEADER;
                  bytes_left_in = 3'd0;
               end else if (item.final_byte) begin
                  res.emit = 1'b1;
                  res.payload.status = ST_TRUNCATED;
               end
            end
            PH_IGNORE: begin
               phase_in = PH_IGNORE;
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase

         if (item.final_byte) begin
            phase_in        = PH_HEADER;
            bytes_left_in   = 3'd0;
            length_size_in  = 3'd0;
            offset_size_in  = 3'd0;
            length_accum_in = '0;
            offset_accum_in = '0;
            prev_cluster_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         bytes_left_ff   <= 3'd0;
         length_size_ff  <= 3'd0;
         offset_size_ff  <= 3'd0;
         length_accum_ff <= '0;
         offset_accum_ff <= '0;
         prev_cluster_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         length_size_ff  <= length_size_in;
         offset_size_ff  <= offset_size_in;
         length_accum_ff <= length_accum_in;
         offset_accum_ff <= offset_accum_in;
         prev_cluster_ff <= prev_cluster_in;
      end
   end

endmodule

// ===== hdl/drd_out_stage.sv =====
module drd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  drd_pkg::step_res_type res,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output drd_pkg::rsp_type      rsp_payload
);
   import drd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type payload_ff;
   logic    load;

   assign free = !valid_ff || !rsp_stall;
   assign load = step && res.emit;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= res.payload;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_payload = payload_ff;

endmodule
